/* rtl/vna_pkg.sv */
// Shared types, widths and operation codes of the vertex normal accumulator.
package vna_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned SUM_BITS_DEF     = 24;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 16;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned CNT_W = 11;
  // Widest vector that reaches the normalizer: a cross product component.
  localparam int unsigned VEC_W = 35;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } norm_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } norm_rsp_t;

endpackage

/* rtl/vna_in_if.sv */
// Input channel of the vertex normal accumulator: valid, ready and one item.
interface vna_in_if import vna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [IDX_W-1:0]        index_a;
  logic [IDX_W-1:0]        index_b;
  logic [IDX_W-1:0]        index_c;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, operation, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, operation, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

/* rtl/vna_out_if.sv */
// Output channel of the vertex normal accumulator: valid, ready and one result item.
interface vna_out_if import vna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    status;

  modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

/* rtl/vna_norm.sv */
// Multi-cycle normalizer: scales a signed vector to a unit vector in Q1.14.
module vna_norm import vna_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  localparam int unsigned SQW    = 24;
  localparam int unsigned FRAC   = NRM_W - 2;
  localparam int unsigned QW     = FRAC + 1;
  localparam int unsigned LEN2_W = 2 * SQW + 2;
  localparam int unsigned LEN_W  = SQW + 1;
  localparam int unsigned NUMW   = SQW + FRAC + 1;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_SQRT  = 7'b0001000,
    N_DSET  = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_OUT   = 7'b1000000
  } nstate_e;

  nstate_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  logic [2:0]            sgn_q;
  logic [VEC_W-1:0]      m_q [3];
  logic [2*SQW-1:0]      sq_q;
  logic [LEN2_W-1:0]     len2_q;
  logic [LEN2_W-1:0]     rem_q;
  logic [LEN2_W-1:0]     root_q;
  logic [LEN2_W-1:0]     bit_q;
  logic [LEN_W-1:0]      len_q;
  logic [LEN_W-1:0]      drem_q [3];
  logic [QW-1:0]         dq_q [3];

  logic                  any_big;
  logic                  all_zero;
  logic [SQW-1:0]        msel;
  logic [2*SQW-1:0]      sq_d;
  logic [LEN2_W:0]       trial;
  logic [LEN_W-1:0]      len_d;
  logic [NUMW-1:0]       num [3];
  logic [LEN_W:0]        dt [3];
  logic signed [NRM_W-1:0] nout [3];

  always_comb begin
    any_big  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_big  = any_big | (m_q[i][VEC_W-1:SQW] != '0);
      all_zero = all_zero & (m_q[i] == '0);
    end
    case (cnt_q[1:0])
      2'd0:    msel = m_q[0][SQW-1:0];
      2'd1:    msel = m_q[1][SQW-1:0];
      default: msel = m_q[2][SQW-1:0];
    endcase
    sq_d  = msel * msel;
    trial = {1'b0, root_q} + {1'b0, bit_q};
    len_d = (root_q[LEN_W-1:0] == '0) ? LEN_W'(1) : root_q[LEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      num[i]  = {1'b0, m_q[i][SQW-1:0], FRAC'(0)} + NUMW'(len_d >> 1);
      dt[i]   = {drem_q[i], dq_q[i][QW-1]};
      nout[i] = sgn_q[i] ? -$signed({1'b0, dq_q[i]}) : $signed({1'b0, dq_q[i]});
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      N_IDLE:  if (req_i.start) state_d = N_SHIFT;
      N_SHIFT: begin
        if (all_zero) begin
          state_d = N_OUT;
        end else if (!any_big) begin
          state_d = N_SQ;
          cnt_d   = '0;
        end
      end
      N_SQ: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          state_d = N_SQRT;
          cnt_d   = '0;
        end
      end
      N_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(LEN_W - 1)) begin
          state_d = N_DSET;
          cnt_d   = '0;
        end
      end
      N_DSET:  state_d = N_DIV;
      N_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(QW - 1)) state_d = N_OUT;
      end
      N_OUT:   state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == N_IDLE && req_i.start) begin
      sgn_q <= {req_i.vz[VEC_W-1], req_i.vy[VEC_W-1], req_i.vx[VEC_W-1]};
      m_q[0] <= req_i.vx[VEC_W-1] ? VEC_W'(-req_i.vx) : VEC_W'(req_i.vx);
      m_q[1] <= req_i.vy[VEC_W-1] ? VEC_W'(-req_i.vy) : VEC_W'(req_i.vy);
      m_q[2] <= req_i.vz[VEC_W-1] ? VEC_W'(-req_i.vz) : VEC_W'(req_i.vz);
    end
    if (state_q == N_SHIFT) begin
      if (all_zero) begin
        for (int i = 0; i < 3; i++) dq_q[i] <= '0;
      end else if (any_big) begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
      end else begin
        len2_q <= '0;
      end
    end
    if (state_q == N_SQ) begin
      sq_q <= sq_d;
      if (cnt_q == 5'd1 || cnt_q == 5'd2) len2_q <= len2_q + LEN2_W'(sq_q);
      if (cnt_q == 5'd3) begin
        rem_q  <= len2_q + LEN2_W'(sq_q);
        root_q <= '0;
        bit_q  <= LEN2_W'(1) << (2 * SQW);
      end
    end
    if (state_q == N_SQRT) begin
      // One result bit per cycle of the digit-by-digit square root.
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[LEN2_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (state_q == N_DSET) begin
      len_q <= len_d;
      for (int i = 0; i < 3; i++) begin
        drem_q[i] <= LEN_W'(num[i][NUMW-1:QW]);
        dq_q[i]   <= num[i][QW-1:0];
      end
    end
    if (state_q == N_DIV) begin
      // Three restoring dividers side by side, one quotient bit per cycle.
      for (int i = 0; i < 3; i++) begin
        if (dt[i] >= {1'b0, len_q}) begin
          drem_q[i] <= LEN_W'(dt[i] - {1'b0, len_q});
          dq_q[i]   <= {dq_q[i][QW-2:0], 1'b1};
        end else begin
          drem_q[i] <= dt[i][LEN_W-1:0];
          dq_q[i]   <= {dq_q[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp_o.done = (state_q == N_OUT);
  assign rsp_o.nx   = nout[0];
  assign rsp_o.ny   = nout[1];
  assign rsp_o.nz   = nout[2];

endmodule

/* rtl/vertex_normal_accumulator_top.sv */
// Top level of the vertex normal accumulator: sequencer, position and sum memories.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+------------------------------------------
//   in_i      | in        | valid / ready      | operation, index_a/b/c, pos_x/y/z
//   out_o     | out       | valid / ready      | normal_x/y/z, status
//   cfg       | in        | cfg_we_i, no ready | cfg_wdata_i = vertex_count
//
// A load, a flagged item or an unused code goes straight to the result. A read item runs its
// sums through the shared normalizer; a triangle item reads its corners through the single
// port of each memory, normalizes its cross product and then updates the sums of each corner.
// The normalizer does up to 9 shift, 25 square root and 15 divide steps, none for a zero vector.
// One item is in work at a time; the next item is accepted as soon as the previous
// result sits in the output register, even while that result waits to be taken.
// Reset clears the sequencer, the output valid and vertex_count; the memories are not
// cleared, so an entry must be loaded before a triangle or read uses it.
module vertex_normal_accumulator_top import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned SUM_BITS     = SUM_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  vna_in_if.sink           in_i,
  vna_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int unsigned PW = 3 * POS_W;
  localparam int unsigned SW = 3 * SUM_BITS;
  localparam int unsigned EW = POS_W + 1;
  localparam int unsigned MW = 2 * EW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_POS    = 9'b000000010,
    S_CROSS  = 9'b000000100,
    S_SUMRD  = 9'b000001000,
    S_NSTART = 9'b000010000,
    S_NWAIT  = 9'b000100000,
    S_RMW_RD = 9'b001000000,
    S_RMW_WR = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  // Maps an item index onto a memory address.
  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [CW-1:0] ext;
    ext = CW'(idx);
    return ext[AW-1:0];
  endfunction

  // An index is flagged when it lies at or beyond the vertex count or the memory depth.
  function automatic logic is_bad(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] vc);
    return (CNT_W'(idx) >= vc) || (CW'(idx) >= CW'(MAX_VERTICES));
  endfunction

  // Adds a unit normal component to a sum, clamping at the signed sum range.
  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [NRM_W-1:0] b);
    logic [SUM_BITS:0] r;
    r = {a[SUM_BITS-1], a} + {{(SUM_BITS + 1 - NRM_W){b[NRM_W-1]}}, b};
    if (r[SUM_BITS] != r[SUM_BITS-1]) begin
      return r[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}} : {1'b0, {(SUM_BITS - 1){1'b1}}};
    end
    return r[SUM_BITS-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0] vc_q;
  logic             out_valid_q;

  logic [1:0]       op_q;
  logic [AW-1:0]    ia_q, ib_q, ic_q;
  logic [PW-1:0]    p_q [3];
  logic signed [MW-1:0]    prod_q;
  logic signed [VEC_W-1:0] c_q [3];
  logic [NRM_W-1:0] ux_q, uy_q, uz_q;
  logic [NRM_W-1:0] res_nx_q, res_ny_q, res_nz_q;
  logic             res_status_q;
  logic [NRM_W-1:0] out_nx_q, out_ny_q, out_nz_q;
  logic             out_status_q;

  // Memories: one port each, read data registered.
  logic [PW-1:0]    pos_mem [MAX_VERTICES];
  logic [SW-1:0]    sum_mem [MAX_VERTICES];
  logic [PW-1:0]    pos_rdata_q;
  logic [SW-1:0]    sum_rdata_q;
  logic [AW-1:0]    pos_addr, sum_addr, corner_addr;
  logic             pos_we, sum_we;
  logic [PW-1:0]    pos_wdata;
  logic [SW-1:0]    sum_wdata;

  logic             in_acc, in_bad, bad_a, bad_b, bad_c;
  logic             out_load;
  logic [2:0]       cm1;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] prod_d;
  logic [SUM_BITS-1:0]  sx, sy, sz;
  norm_req_t        nreq;
  norm_rsp_t        nrsp;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign bad_a      = is_bad(in_i.index_a, vc_q);
  assign bad_b      = is_bad(in_i.index_b, vc_q);
  assign bad_c      = is_bad(in_i.index_c, vc_q);

  always_comb begin
    unique case (in_i.operation) inside
      OP_LOAD, OP_READ: in_bad = bad_a;
      OP_TRI:           in_bad = bad_a | bad_b | bad_c;
      default:          in_bad = 1'b0;
    endcase
  end

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    corner_addr = ia_q;
      2'd1:    corner_addr = ib_q;
      default: corner_addr = ic_q;
    endcase
  end

  assign sx = sum_rdata_q[SW-1 -: SUM_BITS];
  assign sy = sum_rdata_q[2*SUM_BITS-1 -: SUM_BITS];
  assign sz = sum_rdata_q[SUM_BITS-1:0];

  // A load writes its position and clears its sums in the cycle it is accepted.
  assign pos_we    = in_acc && (in_i.operation == OP_LOAD) && !bad_a;
  assign pos_wdata = {in_i.pos_x, in_i.pos_y, in_i.pos_z};
  assign pos_addr  = (state_q == S_IDLE) ? to_addr(in_i.index_a) : corner_addr;

  // Each triangle corner is read in S_RMW_RD, then written with the saturated sum in S_RMW_WR.
  // Corners are visited one after another, so a repeated corner sees its own update.
  assign sum_we    = pos_we || (state_q == S_RMW_WR);
  assign sum_wdata = pos_we ? '0 : {sat_add(sx, ux_q), sat_add(sy, uy_q), sat_add(sz, uz_q)};
  always_comb begin
    if (state_q == S_IDLE) begin
      sum_addr = to_addr(in_i.index_a);
    end else if (state_q == S_RMW_RD || state_q == S_RMW_WR) begin
      sum_addr = corner_addr;
    end else begin
      sum_addr = ia_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wdata;
    pos_rdata_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_rdata_q <= sum_mem[sum_addr];
  end

  // Edge vectors of the triangle, and one shared multiplier for the cross product.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = $signed({p_q[1][PW-1-i*POS_W], p_q[1][PW-1-i*POS_W -: POS_W]})
            - $signed({p_q[0][PW-1-i*POS_W], p_q[0][PW-1-i*POS_W -: POS_W]});
      e2[i] = $signed({p_q[2][PW-1-i*POS_W], p_q[2][PW-1-i*POS_W -: POS_W]})
            - $signed({p_q[0][PW-1-i*POS_W], p_q[0][PW-1-i*POS_W -: POS_W]});
    end
    case (cnt_q)
      3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
      default: begin mul_a = e1[1]; mul_b = e2[0]; end
    endcase
    prod_d = mul_a * mul_b;
  end

  assign cm1 = cnt_q - 3'd1;

  always_comb begin
    nreq.start = (state_q == S_NSTART);
    if (op_q == OP_TRI) begin
      nreq.vx = c_q[0];
      nreq.vy = c_q[1];
      nreq.vz = c_q[2];
    end else begin
      nreq.vx = VEC_W'($signed(sx));
      nreq.vy = VEC_W'($signed(sy));
      nreq.vz = VEC_W'($signed(sz));
    end
  end

  vna_norm u_norm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (nreq),
    .rsp_o (nrsp)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if (in_bad) begin
            state_d = S_DONE;
          end else begin
            case (in_i.operation)
              OP_TRI:  state_d = S_POS;
              OP_READ: state_d = S_SUMRD;
              default: state_d = S_DONE;
            endcase
          end
        end
      end
      S_POS: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          state_d = S_CROSS;
          cnt_d   = '0;
        end
      end
      S_CROSS: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd6) begin
          state_d = S_NSTART;
          cnt_d   = '0;
        end
      end
      S_SUMRD:  state_d = S_NSTART;
      S_NSTART: state_d = S_NWAIT;
      S_NWAIT: begin
        if (nrsp.done) state_d = (op_q == OP_TRI) ? S_RMW_RD : S_DONE;
      end
      S_RMW_RD: state_d = S_RMW_WR;
      S_RMW_WR: begin
        if (cnt_q == 3'd2) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = S_RMW_RD;
        end
      end
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      vc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) vc_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q         <= in_i.operation;
      ia_q         <= to_addr(in_i.index_a);
      ib_q         <= to_addr(in_i.index_b);
      ic_q         <= to_addr(in_i.index_c);
      res_status_q <= in_bad;
      res_nx_q     <= '0;
      res_ny_q     <= '0;
      res_nz_q     <= '0;
    end
    if (state_q == S_POS && cnt_q != 3'd0) p_q[cm1[1:0]] <= pos_rdata_q;
    if (state_q == S_CROSS) begin
      if (cnt_q != 3'd6) prod_q <= prod_d;
      if (cnt_q != 3'd0) begin
        if (!cm1[0]) begin
          c_q[cm1[2:1]] <= VEC_W'(prod_q);
        end else begin
          c_q[cm1[2:1]] <= c_q[cm1[2:1]] - VEC_W'(prod_q);
        end
      end
    end
    if (state_q == S_NWAIT && nrsp.done) begin
      if (op_q == OP_TRI) begin
        ux_q <= nrsp.nx;
        uy_q <= nrsp.ny;
        uz_q <= nrsp.nz;
      end else begin
        res_nx_q <= nrsp.nx;
        res_ny_q <= nrsp.ny;
        res_nz_q <= nrsp.nz;
      end
    end
    if (out_load) begin
      out_nx_q     <= res_nx_q;
      out_ny_q     <= res_ny_q;
      out_nz_q     <= res_nz_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.normal_x = out_nx_q;
  assign out_o.normal_y = out_ny_q;
  assign out_o.normal_z = out_nz_q;
  assign out_o.status   = out_status_q;

endmodule

/* rtl/vna_chk.sv */
// Port-level checker of the vertex normal accumulator and its bind statement.
module vna_chk import vna_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [NRM_W-1:0] normal_x_i,
  input logic signed [NRM_W-1:0] normal_y_i,
  input logic signed [NRM_W-1:0] normal_z_i,
  input logic                    status_i
);

  // Only one item is in work, so the block is busy right after it takes one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again right after an accept");

  // A flagged item carries a zero normal.
  a_flagged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |->
      normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0)
    else $error("flagged item with a nonzero normal");

  // Unit normal components stay within plus or minus one in Q1.14.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      normal_x_i >= -16'sd16384 && normal_x_i <= 16'sd16384 &&
      normal_y_i >= -16'sd16384 && normal_y_i <= 16'sd16384 &&
      normal_z_i >= -16'sd16384 && normal_z_i <= 16'sd16384)
    else $error("normal component out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(normal_x_i) && $stable(normal_y_i) &&
      $stable(normal_z_i) && $stable(status_i))
    else $error("stalled result changed");

endmodule

bind vertex_normal_accumulator_top vna_chk u_vna_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .normal_x_i (out_o.normal_x),
  .normal_y_i (out_o.normal_y),
  .normal_z_i (out_o.normal_z),
  .status_i   (out_o.status)
);
